### rtl/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types and constants for the allocation free checker.
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int ADDR_WIDTH_DEF  = 32;

    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;
    localparam int BYTES_W  = 38;

    localparam logic [STATUS_W-1:0] STAT_FREED     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_ALLOC = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_DOUBLE    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_INTERIOR  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_RECORDED  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

endpackage

### rtl/afc_ram.sv
// ----------------------------------------------------------------------------
// afc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module afc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/allocation_free_checker.sv
// ----------------------------------------------------------------------------
// allocation_free_checker
// Allocation table with exact-match, double-free and interior-address checks.
// ----------------------------------------------------------------------------
// Records live in one table RAM in insertion order (base, size, in-use flag).
// A record command (0) appends an entry, or reports table full, and its result
// is registered out from S_DONE once the output is free. A free check (1) reads
// the table one entry per cycle through the RAM read port, oldest first, and
// stops at the first in-use exact match (freed) or in-use block holding the
// address strictly inside [base, base+size) (interior); otherwise it reports
// double free or not allocated. One item is in work at a time; a new item is
// taken while the previous result waits on m_. The table needs no clearing
// after reset: only entries below record_count are read.
module allocation_free_checker #(
    parameter int TABLE_DEPTH = afc_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_WIDTH  = afc_pkg::ADDR_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_command,
    input  logic [afc_pkg::ADDR_W-1:0]     s_address,
    input  logic [afc_pkg::SIZE_W-1:0]     s_block_size,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [afc_pkg::STATUS_W-1:0]   m_status,
    output logic [afc_pkg::COUNT_W-1:0]    m_record_count,
    output logic [afc_pkg::COUNT_W-1:0]    m_active_count,
    output logic [afc_pkg::BYTES_W-1:0]    m_active_bytes
);
    import afc_pkg::*;

    localparam int BASE_W = (ADDR_WIDTH < ADDR_W) ? ADDR_WIDTH : ADDR_W;
    localparam int WORD_W = BASE_W + SIZE_W + 1;
    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   held_reg, held_next;
    logic [CNT_W-1:0]   live_reg, live_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;

    logic               m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [COUNT_W-1:0] m_rcnt_reg, m_rcnt_next;
    logic [COUNT_W-1:0] m_acnt_reg, m_acnt_next;
    logic [BYTES_W-1:0] m_bytes_reg, m_bytes_next;

    logic [BASE_W-1:0]   addr_reg, addr_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [STATUS_W-1:0] pend_reg, pend_next;
    logic [IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                seen_reg, seen_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic [BASE_W-1:0] rd_base;
    logic [SIZE_W-1:0] rd_size;
    logic              rd_used;
    logic [BASE_W-1:0] diff;
    logic              issue;
    logic              out_free;

    logic [CNT_W+COUNT_W-1:0] held_ext, live_ext;

    afc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_base = ram_rdata[WORD_W-1 -: BASE_W];
    assign rd_size = ram_rdata[SIZE_W:1];
    assign rd_used = ram_rdata[0];
    assign diff    = addr_reg - rd_base;
    assign issue   = (idx_reg < held_reg);
    assign out_free = !m_valid_reg || m_ready;

    assign held_ext = {{COUNT_W{1'b0}}, held_next};
    assign live_ext = {{COUNT_W{1'b0}}, live_next};

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        held_next     = held_reg;
        live_next     = live_reg;
        bytes_next    = bytes_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_rcnt_next   = m_rcnt_reg;
        m_acnt_next   = m_acnt_reg;
        m_bytes_next  = m_bytes_reg;
        addr_next     = addr_reg;
        size_next     = size_reg;
        pend_next     = pend_reg;
        hit_idx_next  = hit_idx_reg;
        idx_next      = idx_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = rd_idx_reg;
        seen_next     = seen_reg;
        ram_we        = 1'b0;
        ram_waddr     = held_reg[IDX_W-1:0];
        ram_wdata     = {addr_reg, size_reg, 1'b1};
        ram_raddr     = idx_reg[IDX_W-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    addr_next = s_address[BASE_W-1:0];
                    size_next = s_block_size;
                    idx_next  = '0;
                    seen_next = 1'b0;
                    if (s_command) begin
                        state_next = S_SCAN;
                    end else begin
                        pend_next  = (held_reg == FULL_CNT) ? STAT_FULL : STAT_RECORDED;
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (issue) begin
                    rd_valid_next = 1'b1;
                    rd_idx_next   = idx_reg[IDX_W-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
                if (rd_valid_reg && rd_base == addr_reg && rd_used) begin
                    pend_next     = STAT_FREED;
                    hit_idx_next  = rd_idx_reg;
                    size_next     = rd_size;
                    rd_valid_next = 1'b0;
                    state_next    = S_DONE;
                end else if (rd_valid_reg && rd_used && rd_base < addr_reg &&
                             SIZE_W'(diff) < rd_size) begin
                    pend_next     = STAT_INTERIOR;
                    rd_valid_next = 1'b0;
                    state_next    = S_DONE;
                end else begin
                    if (rd_valid_reg && rd_base == addr_reg) begin
                        seen_next = 1'b1;
                    end
                    if (!issue) begin
                        pend_next  = seen_next ? STAT_DOUBLE : STAT_NOT_ALLOC;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    if (pend_reg == STAT_RECORDED) begin
                        ram_we     = 1'b1;
                        held_next  = held_reg + 1'b1;
                        live_next  = live_reg + 1'b1;
                        bytes_next = bytes_reg + BYTES_W'(size_reg);
                    end else if (pend_reg == STAT_FREED) begin
                        ram_we     = 1'b1;
                        ram_waddr  = hit_idx_reg;
                        ram_wdata  = {addr_reg, size_reg, 1'b0};
                        live_next  = live_reg - 1'b1;
                        bytes_next = bytes_reg - BYTES_W'(size_reg);
                    end
                    m_valid_next  = 1'b1;
                    m_status_next = pend_reg;
                    m_rcnt_next   = held_ext[COUNT_W-1:0];
                    m_acnt_next   = live_ext[COUNT_W-1:0];
                    m_bytes_next  = bytes_next;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            held_reg     <= '0;
            live_reg     <= '0;
            bytes_reg    <= '0;
            m_valid_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            held_reg     <= held_next;
            live_reg     <= live_next;
            bytes_reg    <= bytes_next;
            m_valid_reg  <= m_valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_rcnt_reg   <= m_rcnt_next;
        m_acnt_reg   <= m_acnt_next;
        m_bytes_reg  <= m_bytes_next;
        addr_reg     <= addr_next;
        size_reg     <= size_next;
        pend_reg     <= pend_next;
        hit_idx_reg  <= hit_idx_next;
        idx_reg      <= idx_next;
        rd_idx_reg   <= rd_idx_next;
        seen_reg     <= seen_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_record_count = m_rcnt_reg;
    assign m_active_count = m_acnt_reg;
    assign m_active_bytes = m_bytes_reg;

endmodule

### tb/sv/tb_allocation_free_checker.sv
// ----------------------------------------------------------------------------
// tb_allocation_free_checker
// Self-checking testbench for the allocation free checker.
// ----------------------------------------------------------------------------
// Drives record and free-check commands through the input channel with random
// gaps on both channels. A model of the allocation table, kept in this file,
// computes the status and the three counters for every accepted transfer. A
// monitor compares each result transfer with the oldest expected entry.
// Directed cases come first (empty table, field extremes, exact/double/interior
// frees, zero-size and duplicate records). They are followed by a receiver
// hold-off, sender pauses, a long random run and a full-table case.
// ----------------------------------------------------------------------------
module tb_allocation_free_checker;
    timeunit 1ns;
    timeprecision 1ps;

    import afc_pkg::*;

    localparam int TBL_DEPTH  = TABLE_DEPTH_DEF;
    localparam bit CMD_RECORD = 1'b0;
    localparam bit CMD_FREE   = 1'b1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  record_count;
        logic [COUNT_W-1:0]  active_count;
        logic [BYTES_W-1:0]  active_bytes;
    } alloc_result_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_command;
    logic [ADDR_W-1:0]   s_address;
    logic [SIZE_W-1:0]   s_block_size;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [COUNT_W-1:0]  m_record_count;
    logic [COUNT_W-1:0]  m_active_count;
    logic [BYTES_W-1:0]  m_active_bytes;

    // allocation table model
    logic [ADDR_W-1:0]  alloc_base [TBL_DEPTH];
    logic [SIZE_W-1:0]  alloc_size [TBL_DEPTH];
    bit                 alloc_live [TBL_DEPTH];
    int                 held_n;
    int                 live_n;
    logic [BYTES_W-1:0] live_sum;

    alloc_result_t pending_results[$];
    int            status_hits[8];
    int            sent_count;
    int            checked_count;
    int            err_count;
    bit            tx_burst;
    bit            rx_burst;
    int            rx_hold_len;
    int            rx_hold_reqs;
    int            rx_stall_left;

    allocation_free_checker u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_address      (s_address),
        .s_block_size   (s_block_size),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_record_count (m_record_count),
        .m_active_count (m_active_count),
        .m_active_bytes (m_active_bytes)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(10_000_000);
        $display("timeout: %0d results still expected", pending_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    function automatic alloc_result_t predict_step(input bit cmd,
                                                   input logic [ADDR_W-1:0] addr,
                                                   input logic [SIZE_W-1:0] size);
        alloc_result_t r;
        bit            seen_freed;
        bit            done;
        r          = '0;
        seen_freed = 1'b0;
        done       = 1'b0;
        if (cmd == CMD_RECORD) begin
            if (held_n >= TBL_DEPTH) begin
                r.status = STAT_FULL;
            end else begin
                alloc_base[held_n] = addr;
                alloc_size[held_n] = size;
                alloc_live[held_n] = 1'b1;
                held_n++;
                live_n++;
                live_sum = live_sum + BYTES_W'(size);
                r.status = STAT_RECORDED;
            end
        end else begin
            for (int i = 0; i < held_n && !done; i++) begin
                if (alloc_base[i] == addr) begin
                    if (alloc_live[i]) begin
                        alloc_live[i] = 1'b0;
                        live_n--;
                        live_sum = live_sum - BYTES_W'(alloc_size[i]);
                        r.status = STAT_FREED;
                        done = 1'b1;
                    end else begin
                        seen_freed = 1'b1;
                    end
                end else if (alloc_live[i] && alloc_base[i] < addr &&
                             (addr - alloc_base[i]) < alloc_size[i]) begin
                    r.status = STAT_INTERIOR;
                    done = 1'b1;
                end
            end
            if (!done)
                r.status = seen_freed ? STAT_DOUBLE : STAT_NOT_ALLOC;
        end
        r.record_count = COUNT_W'(held_n);
        r.active_count = COUNT_W'(live_n);
        r.active_bytes = live_sum;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (err_count < 40)
            $display("mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
                     field, checked_count, got, want);
        err_count++;
    endtask

    task automatic send_item(input bit cmd, input logic [ADDR_W-1:0] addr,
                             input logic [SIZE_W-1:0] size);
        int            gap;
        alloc_result_t want;
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_address    <= addr;
        s_block_size <= size;
        do @(posedge aclk); while (!s_ready);
        want = predict_step(cmd, addr, size);
        pending_results.push_back(want);
        status_hits[want.status]++;
        sent_count++;
    endtask

    // drop valid and hold until every expected result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    function automatic logic [ADDR_W-1:0] pick_free_address();
        int                sel;
        int                idx;
        logic [ADDR_W-1:0] b;
        logic [SIZE_W-1:0] sz;
        sel = $urandom_range(0, 99);
        if (held_n == 0 || sel >= 80)
            return $urandom;
        idx = $urandom_range(0, held_n - 1);
        b   = alloc_base[idx];
        sz  = alloc_size[idx];
        if (sel < 35)
            return b;
        if (sel < 60)
            return (sz > 1) ? b + $urandom_range(sz - 1, 1) : b + 1;
        if (sel < 70)
            return b + sz;
        return b - 1;
    endfunction

    task automatic test_empty_table();
        send_item(CMD_FREE, 32'h0000_0000, 32'h0);
        send_item(CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain_results();
    endtask

    task automatic test_record_extremes();
        send_item(CMD_RECORD, 32'h0000_0000, 32'h0000_0000);
        send_item(CMD_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_RECORD, 32'h0000_1000, 32'h0000_0100);
        send_item(CMD_RECORD, 32'h8000_0000, 32'h7FFF_FFFF);
        drain_results();
    endtask

    task automatic test_free_classes();
        // zero-size block never holds an interior address
        send_item(CMD_FREE, 32'h0000_0001, 32'h0);
        send_item(CMD_FREE, 32'h0000_0000, 32'h0);
        send_item(CMD_FREE, 32'h0000_1000, 32'h0);
        send_item(CMD_FREE, 32'h0000_1000, 32'h0);
        send_item(CMD_FREE, 32'h0000_1080, 32'h0);
        send_item(CMD_RECORD, 32'h0000_2000, 32'h0000_0100);
        send_item(CMD_FREE, 32'h0000_20FF, 32'h0);
        send_item(CMD_FREE, 32'h0000_2100, 32'h0);
        send_item(CMD_FREE, 32'h0000_1FFF, 32'h0);
        drain_results();
    endtask

    task automatic test_duplicate_bases();
        send_item(CMD_RECORD, 32'h0000_3000, 32'h0000_0010);
        send_item(CMD_RECORD, 32'h0000_3000, 32'h0000_0020);
        send_item(CMD_FREE, 32'h0000_3000, 32'h0);
        send_item(CMD_FREE, 32'h0000_3000, 32'h0);
        send_item(CMD_FREE, 32'h0000_3000, 32'h0);
        send_item(CMD_FREE, 32'hFFFF_FFFE, 32'h0);
        drain_results();
    endtask

    // receiver holds off while the sender keeps offering back-to-back transfers
    task automatic test_receiver_holdoff();
        tx_burst    = 1'b1;
        rx_hold_len = 300;
        rx_hold_reqs++;
        repeat (12) begin
            if ($urandom_range(0, 1) == 0)
                send_item(CMD_FREE, pick_free_address(), $urandom);
            else
                send_item(CMD_RECORD, $urandom, $urandom_range(1, 4096));
        end
        tx_burst = 1'b0;
        drain_results();
    endtask

    task automatic test_sender_pauses();
        repeat (3) begin
            repeat (6)
                send_item(CMD_FREE, pick_free_address(), $urandom);
            drain_results();
        end
    endtask

    task automatic test_random_traffic(input int count);
        int                sel;
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] size;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                tx_burst = ($urandom_range(0, 3) == 0);
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 15) == 0) begin
                sel  = $urandom_range(0, 99);
                base = (held_n != 0 && sel < 15) ? alloc_base[$urandom_range(0, held_n - 1)]
                                                 : $urandom;
                sel  = $urandom_range(0, 99);
                if (sel < 20)
                    size = '0;
                else if (sel < 60)
                    size = $urandom_range(1, 4096);
                else if (sel < 85)
                    size = $urandom;
                else if (sel < 95)
                    size = '1;
                else
                    size = 1;
                send_item(CMD_RECORD, base, size);
            end else begin
                send_item(CMD_FREE, pick_free_address(), $urandom);
            end
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        drain_results();
    endtask

    task automatic test_table_full();
        while (held_n < TBL_DEPTH)
            send_item(CMD_RECORD, $urandom, $urandom_range(0, 255));
        repeat (3)
            send_item(CMD_RECORD, $urandom, $urandom);
        send_item(CMD_FREE, alloc_base[TBL_DEPTH - 1], $urandom);
        send_item(CMD_RECORD, 32'h0000_4000, 32'h0000_0040);
        send_item(CMD_FREE, pick_free_address(), $urandom);
        drain_results();
    endtask

    // receiver: random stall after each transfer, or a long hold on request
    initial begin
        int hold_seen;
        hold_seen     = 0;
        rx_stall_left = 0;
        m_ready       = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_reqs != hold_seen) begin
                hold_seen     = rx_hold_reqs;
                rx_stall_left = rx_hold_len;
            end else if (m_valid && m_ready) begin
                rx_stall_left = rx_burst ? 0 : $urandom_range(0, 14);
            end else if (rx_stall_left != 0) begin
                rx_stall_left--;
            end
            m_ready <= (rx_stall_left == 0);
        end
    end

    initial begin
        alloc_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with none expected", 64'(m_status), 64'(0));
                end else begin
                    want = pending_results.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", 64'(m_status), 64'(want.status));
                    if (m_record_count !== want.record_count)
                        report_mismatch("record_count", 64'(m_record_count),
                                        64'(want.record_count));
                    if (m_active_count !== want.active_count)
                        report_mismatch("active_count", 64'(m_active_count),
                                        64'(want.active_count));
                    if (m_active_bytes !== want.active_bytes)
                        report_mismatch("active_bytes", 64'(m_active_bytes),
                                        64'(want.active_bytes));
                end
                checked_count++;
            end
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_command    = 1'b0;
        s_address    = '0;
        s_block_size = '0;
        held_n       = 0;
        live_n       = 0;
        live_sum     = '0;
        sent_count   = 0;
        checked_count = 0;
        err_count    = 0;
        tx_burst     = 1'b0;
        rx_burst     = 1'b0;
        rx_hold_len  = 0;
        rx_hold_reqs = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_record_extremes();
        test_free_classes();
        test_duplicate_bases();
        test_receiver_holdoff();
        test_sender_pauses();
        test_random_traffic(1500);
        test_table_full();

        repeat (TBL_DEPTH + 16) @(posedge aclk);
        $display("summary: %0d transfers in, %0d results checked, %0d of %0d entries held",
                 sent_count, checked_count, held_n, TBL_DEPTH);
        $display("statuses: freed %0d, not allocated %0d, double %0d,",
                 status_hits[STAT_FREED], status_hits[STAT_NOT_ALLOC],
                 status_hits[STAT_DOUBLE]);
        $display("          interior %0d, recorded %0d, full %0d",
                 status_hits[STAT_INTERIOR], status_hits[STAT_RECORDED],
                 status_hits[STAT_FULL]);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
